@@ hw/rtl/sphk_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, kernel tables and arithmetic helpers for the SPH spline kernel core.
// No dependencies; used by sph_spline_kernel_eval_core.
package sphk_pkg;

  localparam int FRAC_BITS_DEF = 16;   // fraction bits of radius and norms
  localparam int WF            = 24;   // internal fraction bits of q and powers

  localparam int RADIUS_W   = 17;
  localparam int KNOT_W     = 3;       // knot position in halves, up to 6
  localparam int QX_W       = RADIUS_W + KNOT_W;
  localparam int DIFF_W     = 26;      // knot minus q, up to 3.0 in Q2.24
  localparam int POW_W      = 32;      // powers up to 3^5 in Q8.24
  localparam int COEF_W     = 8;
  localparam int TERM_W     = 40;
  localparam int SUM_W      = 42;
  localparam int NORM_W     = 32;
  localparam int OUT_W      = 32;
  localparam int KIND_W     = 2;
  localparam int NUM_KNOTS  = 3;
  localparam int PIPE_DEPTH = 9;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 2;

  localparam int CUBIC_DSHIFT = 2;

  localparam logic [KIND_W-1:0] KIND_CUBIC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUINTIC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUARTIC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_NORM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_NORM  = 2'd2;

  localparam logic [NORM_W-1:0] NORM_RST = 32'd65536;

  // Knot positions in halves of q; a knot at zero is never in support.
  function automatic logic [KNOT_W-1:0] knot_halves(logic [KIND_W-1:0] kind, logic [1:0] idx);
    logic [KNOT_W-1:0] kn;
    kn = '0;
    case (kind)
      KIND_CUBIC: begin
        case (idx)
          2'd0:    kn = 3'd4;
          2'd1:    kn = 3'd2;
          default: kn = 3'd0;
        endcase
      end
      KIND_QUINTIC: begin
        case (idx)
          2'd0:    kn = 3'd6;
          2'd1:    kn = 3'd4;
          2'd2:    kn = 3'd2;
          default: kn = 3'd0;
        endcase
      end
      KIND_QUARTIC: begin
        case (idx)
          2'd0:    kn = 3'd5;
          2'd1:    kn = 3'd3;
          2'd2:    kn = 3'd1;
          default: kn = 3'd0;
        endcase
      end
      default: kn = 3'd0;
    endcase
    return kn;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_value(logic [KIND_W-1:0] kind,
                                                          logic [1:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (kind)
      KIND_CUBIC: begin
        case (idx)
          2'd0:    c = 8'sd1;
          2'd1:    c = -8'sd4;
          default: c = 8'sd0;
        endcase
      end
      KIND_QUINTIC: begin
        case (idx)
          2'd0:    c = 8'sd1;
          2'd1:    c = -8'sd6;
          2'd2:    c = 8'sd15;
          default: c = 8'sd0;
        endcase
      end
      KIND_QUARTIC: begin
        case (idx)
          2'd0:    c = 8'sd1;
          2'd1:    c = -8'sd5;
          2'd2:    c = 8'sd10;
          default: c = 8'sd0;
        endcase
      end
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_slope(logic [KIND_W-1:0] kind,
                                                          logic [1:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (kind)
      KIND_CUBIC: begin
        case (idx)
          2'd0:    c = -8'sd3;
          2'd1:    c = 8'sd12;
          default: c = 8'sd0;
        endcase
      end
      KIND_QUINTIC: begin
        case (idx)
          2'd0:    c = -8'sd5;
          2'd1:    c = 8'sd30;
          2'd2:    c = -8'sd75;
          default: c = 8'sd0;
        endcase
      end
      KIND_QUARTIC: begin
        case (idx)
          2'd0:    c = -8'sd4;
          2'd1:    c = 8'sd20;
          2'd2:    c = -8'sd40;
          default: c = 8'sd0;
        endcase
      end
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // One step of the power chain: p * d rounded half up to WF fraction bits.
  function automatic logic [POW_W-1:0] pow_step(logic [POW_W-1:0] p, logic [DIFF_W-1:0] d);
    logic [POW_W+DIFF_W-1:0] prod;
    logic [POW_W+DIFF_W:0]   rsum;
    prod = (POW_W + DIFF_W)'(p) * (POW_W + DIFF_W)'(d);
    rsum = (POW_W + DIFF_W + 1)'(prod) + ((POW_W + DIFF_W + 1)'(1) << (WF - 1));
    return rsum[WF+POW_W-1:WF];
  endfunction

endpackage

@@ hw/rtl/sph_spline_kernel_eval_core.sv @@
`timescale 1ns / 1ps
// SPH spline kernel evaluator: value and radial slope of the cubic, quintic or quartic kernel.
// Depends on sphk_pkg for widths, knot and coefficient tables and the power-step helper.

// One scaled radius enters per clock unless the output stalls, and its kernel value and slope
// leave after the nine register stages; the sustained rate is one request per cycle while
// m_axis_tready stays high. The nine register stages are: support offset (q against each
// knot), four stages of the power chain d^2..d^5 (one 32x26 multiplier per knot each),
// coefficient products, summing with the cubic divide by four, the normalization multiply,
// and rounding with saturation. Each stage holds its own valid bit, so a stall at the output
// fills bubbles before it pushes back on the input. Configuration must be written only while the pipeline is empty.
module sph_spline_kernel_eval_core #(
  parameter int FRAC_BITS = sphk_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sphk_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [16:0] scaled_radius
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sphk_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [31:0] kernel_value,
                                                              // [63:32] kernel_slope
  input  logic                                cfg_we,
  input  logic [sphk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sphk_pkg::NORM_W-1:0]         cfg_wdata
);

  localparam int NST  = sphk_pkg::PIPE_DEPTH;
  localparam int NK   = sphk_pkg::NUM_KNOTS;
  localparam int SH   = sphk_pkg::WF - 1 - FRAC_BITS;
  localparam int SHL  = (SH > 0) ? SH : 0;
  localparam int SHR  = (SH < 0) ? -SH : 0;
  localparam int QRND = (SHR > 0) ? (1 << (SHR - 1)) : 0;
  localparam int QW_RAW = sphk_pkg::QX_W + SHL + 1;
  localparam int QW   = (QW_RAW > sphk_pkg::DIFF_W + 1) ? QW_RAW : sphk_pkg::DIFF_W + 1;

  localparam int DW = sphk_pkg::DIFF_W;
  localparam int PW = sphk_pkg::POW_W;
  localparam int TW = sphk_pkg::TERM_W;
  localparam int SW = sphk_pkg::SUM_W;
  localparam int NW = sphk_pkg::NORM_W;
  localparam int OW = sphk_pkg::OUT_W;
  localparam int KW = sphk_pkg::KIND_W;

  // Configuration registers.
  logic [KW-1:0] kernel_kind;
  logic [NW-1:0] value_norm;
  logic [NW-1:0] slope_norm;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_kind <= sphk_pkg::KIND_CUBIC;
      value_norm  <= sphk_pkg::NORM_RST;
      slope_norm  <= sphk_pkg::NORM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sphk_pkg::CFG_KERNEL_KIND: kernel_kind <= cfg_wdata[KW-1:0];
        sphk_pkg::CFG_VALUE_NORM:  value_norm  <= cfg_wdata;
        sphk_pkg::CFG_SLOPE_NORM:  slope_norm  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage load enables; a stage loads when it is empty or moves on.
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v[NST-1] || m_axis_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 1: q = u * support in Q.24, then distance to each knot.
  logic [sphk_pkg::RADIUS_W-1:0] radius;
  logic [sphk_pkg::KNOT_W-1:0]   knot0;
  logic [sphk_pkg::QX_W-1:0]     qx;
  logic [QW-1:0]                 q;
  logic [QW-1:0]                 kn    [NK];
  logic [DW-1:0]                 d_next[NK];

  always_comb begin
    radius = s_axis_tdata[sphk_pkg::RADIUS_W-1:0];
    knot0  = sphk_pkg::knot_halves(kernel_kind, 2'd0);
    qx     = sphk_pkg::QX_W'(radius) * sphk_pkg::QX_W'(knot0);
    q      = ((QW'(qx) + QW'(QRND)) << SHL) >> SHR;
    for (int k = 0; k < NK; k++) begin
      kn[k] = QW'(sphk_pkg::knot_halves(kernel_kind, 2'(k))) << (sphk_pkg::WF - 1);
      d_next[k] = (q < kn[k]) ? DW'(kn[k] - q) : '0;
    end
  end

  logic [KW-1:0] kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
  logic [DW-1:0] d_s1[NK];
  logic [DW-1:0] d_s2[NK];
  logic [DW-1:0] d_s3[NK];
  logic [DW-1:0] d_s4[NK];
  logic [PW-1:0] p2_s2[NK];
  logic [PW-1:0] p2_s3[NK];
  logic [PW-1:0] p2_s4[NK];
  logic [PW-1:0] p2_s5[NK];
  logic [PW-1:0] p3_s3[NK];
  logic [PW-1:0] p3_s4[NK];
  logic [PW-1:0] p3_s5[NK];
  logic [PW-1:0] p4_s4[NK];
  logic [PW-1:0] p4_s5[NK];
  logic [PW-1:0] p5_s5[NK];

  // Stage 6 operands.
  logic [PW-1:0]        pw_sel[NK];
  logic [PW-1:0]        pd_sel[NK];
  logic signed [TW-1:0] tw_next[NK];
  logic signed [TW-1:0] td_next[NK];
  logic signed [TW-1:0] tw_s6[NK];
  logic signed [TW-1:0] td_s6[NK];

  always_comb begin
    for (int k = 0; k < NK; k++) begin
      case (kind_s5)
        sphk_pkg::KIND_QUINTIC: begin
          pw_sel[k] = p5_s5[k];
          pd_sel[k] = p4_s5[k];
        end
        sphk_pkg::KIND_QUARTIC: begin
          pw_sel[k] = p4_s5[k];
          pd_sel[k] = p3_s5[k];
        end
        default: begin
          pw_sel[k] = p3_s5[k];
          pd_sel[k] = p2_s5[k];
        end
      endcase
      tw_next[k] = TW'($signed({1'b0, pw_sel[k]}))
                 * TW'(sphk_pkg::coef_value(kind_s5, 2'(k)));
      td_next[k] = TW'($signed({1'b0, pd_sel[k]}))
                 * TW'(sphk_pkg::coef_slope(kind_s5, 2'(k)));
    end
  end

  // Stage 7: sum the knot terms, take sign and magnitude, round the cubic quarter.
  logic signed [SW-1:0] sum_w, sum_d;
  logic [SW-1:0]        abs_w, abs_d;
  logic [SW-1:0]        rnd_w, rnd_d;
  logic                 neg_w7, neg_d7;
  logic [NW-1:0]        mag_w7, mag_d7;

  always_comb begin
    sum_w = SW'(tw_s6[0]) + SW'(tw_s6[1]) + SW'(tw_s6[2]);
    sum_d = SW'(td_s6[0]) + SW'(td_s6[1]) + SW'(td_s6[2]);
    abs_w = sum_w[SW-1] ? SW'(-sum_w) : SW'(sum_w);
    abs_d = sum_d[SW-1] ? SW'(-sum_d) : SW'(sum_d);
    // Rounding the magnitude gives round half away from zero on the signed sum.
    if (kind_s6 == sphk_pkg::KIND_CUBIC) begin
      rnd_w = (abs_w + (SW'(1) << (sphk_pkg::CUBIC_DSHIFT - 1))) >> sphk_pkg::CUBIC_DSHIFT;
      rnd_d = (abs_d + (SW'(1) << (sphk_pkg::CUBIC_DSHIFT - 1))) >> sphk_pkg::CUBIC_DSHIFT;
    end else begin
      rnd_w = abs_w;
      rnd_d = abs_d;
    end
  end

  // Stage 8: normalization products.
  logic             neg_w8, neg_d8;
  logic [2*NW-1:0]  prod_w8, prod_d8;

  // Stage 9: round to the output fraction and saturate.
  logic [2*NW:0]    rsum_w, rsum_d;
  logic [2*NW-sphk_pkg::WF:0] r_w, r_d;
  logic [OW-1:0]    val_next, slp_next;
  logic [OW-1:0]    kernel_value, kernel_slope;

  localparam logic [OW-1:0] SAT_POS = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] SAT_NEG = {1'b1, {(OW-1){1'b0}}};

  always_comb begin
    rsum_w = (2*NW+1)'(prod_w8) + ((2*NW+1)'(1) << (sphk_pkg::WF - 1));
    rsum_d = (2*NW+1)'(prod_d8) + ((2*NW+1)'(1) << (sphk_pkg::WF - 1));
    r_w = rsum_w[2*NW:sphk_pkg::WF];
    r_d = rsum_d[2*NW:sphk_pkg::WF];
    if (neg_w8) begin
      val_next = (r_w >= ($bits(r_w))'(SAT_NEG)) ? SAT_NEG : OW'(-r_w[OW-1:0]);
    end else begin
      val_next = (r_w > ($bits(r_w))'(SAT_POS)) ? SAT_POS : r_w[OW-1:0];
    end
    if (neg_d8) begin
      slp_next = (r_d >= ($bits(r_d))'(SAT_NEG)) ? SAT_NEG : OW'(-r_d[OW-1:0]);
    end else begin
      slp_next = (r_d > ($bits(r_d))'(SAT_POS)) ? SAT_POS : r_d[OW-1:0];
    end
  end

  // Payload registers; none need reset.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      kind_s1 <= kernel_kind;
      d_s1    <= d_next;
    end
    if (en[1]) begin
      kind_s2 <= kind_s1;
      d_s2    <= d_s1;
      for (int k = 0; k < NK; k++) begin
        p2_s2[k] <= sphk_pkg::pow_step(PW'(d_s1[k]), d_s1[k]);
      end
    end
    if (en[2]) begin
      kind_s3 <= kind_s2;
      d_s3    <= d_s2;
      p2_s3   <= p2_s2;
      for (int k = 0; k < NK; k++) begin
        p3_s3[k] <= sphk_pkg::pow_step(p2_s2[k], d_s2[k]);
      end
    end
    if (en[3]) begin
      kind_s4 <= kind_s3;
      d_s4    <= d_s3;
      p2_s4   <= p2_s3;
      p3_s4   <= p3_s3;
      for (int k = 0; k < NK; k++) begin
        p4_s4[k] <= sphk_pkg::pow_step(p3_s3[k], d_s3[k]);
      end
    end
    if (en[4]) begin
      kind_s5 <= kind_s4;
      p2_s5   <= p2_s4;
      p3_s5   <= p3_s4;
      p4_s5   <= p4_s4;
      for (int k = 0; k < NK; k++) begin
        p5_s5[k] <= sphk_pkg::pow_step(p4_s4[k], d_s4[k]);
      end
    end
    if (en[5]) begin
      kind_s6 <= kind_s5;
      tw_s6   <= tw_next;
      td_s6   <= td_next;
    end
    if (en[6]) begin
      neg_w7 <= sum_w[SW-1];
      neg_d7 <= sum_d[SW-1];
      mag_w7 <= rnd_w[NW-1:0];
      mag_d7 <= rnd_d[NW-1:0];
    end
    if (en[7]) begin
      neg_w8  <= neg_w7;
      neg_d8  <= neg_d7;
      prod_w8 <= (2*NW)'(value_norm) * (2*NW)'(mag_w7);
      prod_d8 <= (2*NW)'(slope_norm) * (2*NW)'(mag_d7);
    end
    if (en[8]) begin
      kernel_value <= val_next;
      kernel_slope <= slp_next;
    end
  end

  assign m_axis_tdata = {kernel_slope, kernel_value};

  // An accepted request always occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v[0])
    else $error("accepted request did not enter the pipeline");

  // A stalled mid-pipeline stage keeps its item and its shape magnitude.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v[6] && !en[6] |=> v[6] && $stable(mag_w7))
    else $error("stalled shape stage lost or changed its item");

  // The cubic kernel has only two knots; the third lane stays out of support.
  a_cubic_lane: assert property (@(posedge clk) disable iff (rst)
    v[0] && kind_s1 == sphk_pkg::KIND_CUBIC |-> d_s1[2] == '0)
    else $error("third knot lane active for cubic kernel");

  // A zero normalized product yields a zero kernel value.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    v[7] && en[8] && prod_w8 == '0 |=> kernel_value == '0)
    else $error("zero product gave nonzero kernel value");

endmodule

@@ verif/sph_kernel_checker.sv @@
`timescale 1ns / 1ps
// Checker for the SPH spline kernel core: tracks register writes, predicts value and slope
// for every accepted radius and compares each returned result in order. Uses sphk_pkg.
module sph_kernel_checker
  import sphk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // [16:0] scaled_radius
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,    // [31:0] kernel_value, [63:32] kernel_slope
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [NORM_W-1:0]      cfg_wdata,
  output int                     mismatch_count,
  output int                     pending_count,
  output int                     checked_count
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [RADIUS_W-1:0] radius;
    logic [OUT_W-1:0]    slope;
    logic [OUT_W-1:0]    value;
  } kernel_expect_t;

  kernel_expect_t expected_kernels [$];

  logic [KIND_W-1:0] kind_reg       = KIND_CUBIC;
  logic [NORM_W-1:0] value_norm_reg = NORM_RST;
  logic [NORM_W-1:0] slope_norm_reg = NORM_RST;
  int                results_seen   = 0;

  initial mismatch_count = 0;
  initial pending_count  = 0;
  initial checked_count  = 0;

  // Repeated multiply, each product rounded half up back to WF fraction bits.
  function automatic logic [63:0] pow_round(input logic [63:0] base, input int degree);
    logic [63:0] acc;
    int          i;
    acc = base;
    for (i = 1; i < degree; i++)
      acc = (acc * base + (64'd1 << (WF - 1))) >> WF;
    return acc;
  endfunction

  function automatic longint round_away(input longint x, input int s);
    logic [63:0] mag;
    if (s == 0)
      return x;
    mag = (x < 0) ? 64'(-x) : 64'(x);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (x < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [OUT_W-1:0] scale_saturate(input logic [NORM_W-1:0] norm,
                                                      input longint shape);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = (shape < 0) ? 64'(-shape) : 64'(shape);
    prod = {32'd0, norm} * mag;
    prod = (prod + (64'd1 << (WF - 1))) >> WF;
    if (shape < 0)
      return (prod >= 64'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - prod[31:0]);
    return (prod > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod[31:0];
  endfunction

  function automatic kernel_expect_t predict_kernel(input logic [KIND_W-1:0]   kind,
                                                    input logic [NORM_W-1:0]   vnorm,
                                                    input logic [NORM_W-1:0]   snorm,
                                                    input logic [RADIUS_W-1:0] radius);
    longint         knot [3];
    longint         cw [3];
    longint         cd [3];
    int             knots;
    int             degree;
    int             dshift;
    int             align;
    int             k;
    logic [63:0]    qx;
    logic [63:0]    q;
    logic [63:0]    kn;
    logic [63:0]    span;
    longint         shape;
    longint         slope;
    kernel_expect_t e;
    shape  = 0;
    slope  = 0;
    knots  = 0;
    degree = 1;
    dshift = 0;
    for (k = 0; k < 3; k++) begin
      knot[k] = 0;
      cw[k]   = 0;
      cd[k]   = 0;
    end
    // Knots are in halves of q; the first knot is also the support.
    case (kind)
      KIND_CUBIC: begin
        knots = 2; degree = 3; dshift = CUBIC_DSHIFT;
        knot[0] = 4;  knot[1] = 2;
        cw[0]   = 1;  cw[1]   = -4;
        cd[0]   = -3; cd[1]   = 12;
      end
      KIND_QUINTIC: begin
        knots = 3; degree = 5;
        knot[0] = 6;  knot[1] = 4;  knot[2] = 2;
        cw[0]   = 1;  cw[1]   = -6; cw[2]   = 15;
        cd[0]   = -5; cd[1]   = 30; cd[2]   = -75;
      end
      KIND_QUARTIC: begin
        knots = 3; degree = 4;
        knot[0] = 5;  knot[1] = 3;  knot[2] = 1;
        cw[0]   = 1;  cw[1]   = -5; cw[2]   = 10;
        cd[0]   = -4; cd[1]   = 20; cd[2]   = -40;
      end
      default: begin
        // The spare kind has no shape, so both outputs stay zero.
        knots = 0;
      end
    endcase
    // radius times knot-in-halves carries one more fraction bit than the radius.
    qx    = 64'(radius) * 64'(knot[0]);
    align = (WF - 1) - FRAC_BITS_DEF;
    if (align >= 0)
      q = qx << align;
    else
      q = (qx + (64'd1 << (-align - 1))) >> (-align);
    for (k = 0; k < knots; k++) begin
      kn = 64'(knot[k]) << (WF - 1);
      if (q < kn) begin
        span  = kn - q;
        shape += cw[k] * longint'(pow_round(span, degree));
        slope += cd[k] * longint'(pow_round(span, degree - 1));
      end
    end
    shape    = round_away(shape, dshift);
    slope    = round_away(slope, dshift);
    e.kind   = kind;
    e.radius = radius;
    e.value  = scale_saturate(vnorm, shape);
    e.slope  = scale_saturate(snorm, slope);
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : monitor
    kernel_expect_t want;
    if (rst) begin
      expected_kernels.delete();
      kind_reg       = KIND_CUBIC;
      value_norm_reg = NORM_RST;
      slope_norm_reg = NORM_RST;
    end else begin
      // A request sees the registers as they stood before this edge.
      if (s_axis_tvalid && s_axis_tready)
        expected_kernels.push_back(predict_kernel(kind_reg, value_norm_reg, slope_norm_reg,
                                                  s_axis_tdata[RADIUS_W-1:0]));
      if (cfg_we) begin
        case (cfg_index)
          CFG_KERNEL_KIND: kind_reg       = cfg_wdata[KIND_W-1:0];
          CFG_VALUE_NORM:  value_norm_reg = cfg_wdata;
          CFG_SLOPE_NORM:  slope_norm_reg = cfg_wdata;
          default:         ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_kernels.size() == 0) begin
          report_mismatch($sformatf("result 0x%016h with no request outstanding",
                                    m_axis_tdata));
        end else begin
          want = expected_kernels.pop_front();
          if (m_axis_tdata[31:0] !== want.value)
            report_mismatch($sformatf("kind %0d radius 0x%05h: kernel_value 0x%08h, want 0x%08h",
                                      want.kind, want.radius, m_axis_tdata[31:0], want.value));
          if (m_axis_tdata[63:32] !== want.slope)
            report_mismatch($sformatf("kind %0d radius 0x%05h: kernel_slope 0x%08h, want 0x%08h",
                                      want.kind, want.radius, m_axis_tdata[63:32], want.slope));
        end
      end
    end
    pending_count <= expected_kernels.size();
    checked_count <= results_seen;
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Top of the SPH spline kernel testbench: clock, reset, register writes and radius stimulus.
// Depends on sphk_pkg, sph_spline_kernel_eval_core and sph_kernel_checker.
module testbench;
  import sphk_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 750;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_WAIT     = 12;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // [16:0] scaled_radius
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [31:0] kernel_value, [63:32] kernel_slope
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_KERNEL_KIND;
  logic [NORM_W-1:0]      cfg_wdata = '0;

  int mismatch_count;
  int pending_count;
  int checked_count;

  logic [KIND_W-1:0] active_kind = KIND_CUBIC;
  int requests_sent   = 0;
  int settings_loaded = 0;
  int kind_requests [4];
  int tx_stretch_left = 0;
  bit tx_no_gaps      = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  sph_spline_kernel_eval_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  sph_kernel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  // Sender and receiver alternate between gap-free stretches and random waits.
  task automatic send_radius(input logic [RADIUS_W-1:0] radius);
    int gap;
    if (tx_stretch_left == 0) begin
      tx_no_gaps      = ($urandom_range(0, 3) == 0);
      tx_stretch_left = $urandom_range(5, 40);
    end
    tx_stretch_left--;
    gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(radius);
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
    kind_requests[active_kind]++;
  endtask

  // Called at the step of the last accepted request; the valid drop is its only update there.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NORM_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [KIND_W-1:0] kind, input logic [NORM_W-1:0] vnorm,
                               input logic [NORM_W-1:0] snorm);
    wait_drained();
    write_reg(CFG_KERNEL_KIND, NORM_W'(kind));
    write_reg(CFG_VALUE_NORM, vnorm);
    write_reg(CFG_SLOPE_NORM, snorm);
    cfg_we <= 1'b0;
    active_kind = kind;
    settings_loaded++;
  endtask

  function automatic logic [KIND_W-1:0] draw_kind();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 7)
      return KIND_UNUSED;
    case (pick % 3)
      0:       return KIND_CUBIC;
      1:       return KIND_QUINTIC;
      default: return KIND_QUARTIC;
    endcase
  endfunction

  function automatic logic [NORM_W-1:0] draw_norm();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return NORM_RST;
      3:       return NORM_W'($urandom_range(0, 32'h00FF_FFFF));
      default: return NORM_W'($urandom());
    endcase
  endfunction

  // Mostly inside the support, some close to a knot crossing, some anywhere.
  function automatic logic [RADIUS_W-1:0] draw_radius();
    int pick;
    int edge_at;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      return RADIUS_W'($urandom_range(0, 65535));
    if (pick < 8) begin
      case ($urandom_range(0, 5))
        0:       edge_at = 32768;
        1:       edge_at = 21845;
        2:       edge_at = 43691;
        3:       edge_at = 13107;
        4:       edge_at = 39322;
        default: edge_at = 65536;
      endcase
      return RADIUS_W'(edge_at + $urandom_range(0, 8) - 4);
    end
    return RADIUS_W'($urandom_range(0, 131071));
  endfunction

  initial begin : result_sink
    int stall;
    int stretch_left;
    bit no_stalls;
    stretch_left = 0;
    no_stalls    = 1'b0;
    wait (!rst);
    forever begin
      if (stretch_left == 0) begin
        no_stalls    = ($urandom_range(0, 3) == 0);
        stretch_left = $urandom_range(5, 40);
      end
      stretch_left--;
      stall = no_stalls ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int random_sent;
    int batch;
    int n;
    random_sent = 0;
    foreach (kind_requests[i]) kind_requests[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Registers as they come out of reset.
    send_radius(17'd0);
    send_radius(17'd40000);

    // Cubic with the largest norms: the peak saturates high, the slope low.
    load_settings(KIND_CUBIC, '1, '1);
    send_radius(17'd0);
    send_radius(17'd1);
    send_radius(17'd32767);
    send_radius(17'd32768);
    send_radius(17'd65535);
    send_radius(17'd65536);
    send_radius(17'h1FFFF);

    // Quintic around its inner knots.
    load_settings(KIND_QUINTIC, NORM_RST, NORM_RST);
    send_radius(17'd0);
    send_radius(17'd21845);
    send_radius(17'd21846);
    send_radius(17'd43690);
    send_radius(17'd43691);
    send_radius(17'd65535);

    load_settings(KIND_QUARTIC, 32'h0012_3457, 32'h0100_0000);
    send_radius(17'd0);
    send_radius(17'd13107);
    send_radius(17'd39321);
    send_radius(17'd65535);
    send_radius(17'd65536);

    // The spare kind must give zeros even with the largest norms.
    load_settings(KIND_UNUSED, '1, '1);
    send_radius(17'd0);
    send_radius(17'd65535);
    send_radius(17'h1FFFF);

    while (random_sent < RANDOM_ITEMS) begin
      load_settings(draw_kind(), draw_norm(), draw_norm());
      batch = $urandom_range(30, 70);
      for (n = 0; n < batch && random_sent < RANDOM_ITEMS; n++) begin
        send_radius(draw_radius());
        random_sent++;
      end
    end

    wait_drained();
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("Run covered %0d radii under %0d register settings: cubic %0d, quintic %0d,",
             requests_sent, settings_loaded, kind_requests[KIND_CUBIC],
             kind_requests[KIND_QUINTIC]);
    $display("quartic %0d, spare kind %0d; %0d results compared, %0d mismatches.",
             kind_requests[KIND_QUARTIC], kind_requests[KIND_UNUSED], checked_count,
             mismatch_count);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sphk_pkg.sv
hw/rtl/sph_spline_kernel_eval_core.sv
verif/sph_kernel_checker.sv
verif/testbench.sv
